FILE: rtl/lpfr_pkg.sv
// Shared constants and types for the LRU page-frame replacement unit.
package lpfr_pkg;

  // Default sizing of the frame table
  localparam int FRAME_COUNT_DEF = 8;
  localparam int PAGE_BITS_DEF   = 16;

  // Fixed port widths
  localparam int IN_PAGE_W  = 16;
  localparam int CFG_W      = 4;
  localparam int OUT_IDX_W  = 3;

  // Active frame count after reset
  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

  // Lookup sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

endpackage

FILE: rtl/lpfr_ram.sv
// Simple dual-port frame table memory: one write port, one registered read port.
module lpfr_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 19,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lru_page_frame_replacement_unit.sv
// A transaction runs two sequential passes over the active frames of the frame table memory
//   (a search pass, then a rank read-modify-write pass), one entry a cycle, and is then
//   loaded into the output register; no new transaction is taken until that load.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n, synchronous): all frames empty, ranks zero, frames_in_use = 8.
// Page contents need no clearing; per-frame valid flops mask unwritten entries.
module lru_page_frame_replacement_unit #(
  parameter int FRAME_COUNT = lpfr_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = lpfr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpfr_pkg::IN_PAGE_W-1:0] in_page_number,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lpfr_pkg::OUT_IDX_W-1:0] out_frame_index,
  output logic                          out_filled_empty,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpfr_pkg::CFG_W-1:0]    cfg_frames_in_use
);

  import lpfr_pkg::*;

  localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
  localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RANK_W  = IDX_W;
  localparam int PW      = PAGE_BITS;
  localparam int ENT_W   = PW + RANK_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAME_COUNT - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]       cfg_frames_r;
  logic [CNT_W-1:0]       n_act;
  logic [CMP_W-1:0]       cfg_ext;

  logic [FRAME_COUNT-1:0] valid_r;
  logic [PW-1:0]          page_r;
  logic [CNT_W-1:0]       rd_idx_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;

  // search accumulators
  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [RANK_W-1:0]      hit_rank_r;
  logic                   empty_r;
  logic [IDX_W-1:0]       empty_idx_r;
  logic [RANK_W-1:0]      best_rank_r;
  logic [IDX_W-1:0]       best_idx_r;

  // update pass controls
  logic [IDX_W-1:0]       f_r;
  logic [RANK_W-1:0]      bound_r;
  logic                   bound_all_r;

  // output register
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [OUT_IDX_W-1:0]   out_frame_index_r;
  logic                   out_filled_empty_r;

  // memory interface
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic                   mem_re;
  logic [ENT_W-1:0]       mem_rdata;

  logic                   in_fire;
  logic                   rd_more;
  logic                   pass_done;
  logic                   ent_valid;
  logic [PW-1:0]          ent_page;
  logic [RANK_W-1:0]      ent_rank;
  logic [IDX_W-1:0]       dec_f;
  logic                   ent_inc;
  logic [RANK_W-1:0]      new_rank;
  logic                   out_load;

  // Active frame count: zero acts as one, clipped at the table size
  assign cfg_ext = CMP_W'(cfg_frames_r);
  always_comb begin
    if (cfg_frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(FRAME_COUNT)) begin
      n_act = CNT_W'(FRAME_COUNT);
    end else begin
      n_act = CNT_W'(cfg_frames_r);
    end
  end

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_frames_r <= cfg_frames_in_use;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Read sequencing shared by both passes
  assign rd_more   = (rd_idx_r < n_act);
  assign pass_done = !rd_more && !pend_r;
  assign mem_re    = ((state_r == S_SCAN) || (state_r == S_UPDATE)) && rd_more;

  // Returned entry; an empty frame reads as rank zero
  assign ent_valid = valid_r[pend_idx_r];
  assign ent_page  = mem_rdata[ENT_W-1:RANK_W];
  assign ent_rank  = ent_valid ? mem_rdata[RANK_W-1:0] : '0;

  // Frame chosen at the end of the search
  always_comb begin
    priority if (hit_r) begin
      dec_f = hit_idx_r;
    end else if (empty_r) begin
      dec_f = empty_idx_r;
    end else begin
      dec_f = best_idx_r;
    end
  end

  // Rank aging for the write-back pass
  assign ent_inc  = ent_valid && (pend_idx_r != f_r) && (ent_rank != RANK_MAX) &&
                    (bound_all_r || (ent_rank < bound_r));
  assign new_rank = ent_inc ? ent_rank + RANK_W'(1) : ent_rank;

  assign mem_we    = (state_r == S_UPDATE) && pend_r;
  assign mem_waddr = pend_idx_r;
  assign mem_wdata = (pend_idx_r == f_r) ? {page_r, RANK_W'(0)} : {ent_page, new_rank};

  lpfr_ram #(
    .DEPTH  (FRAME_COUNT),
    .WIDTH  (ENT_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_SCAN;
      S_SCAN:   if (pass_done) state_nxt = S_UPDATE;
      S_UPDATE: if (pass_done) state_nxt = S_RESULT;
      S_RESULT: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Read address counter and return pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      pend_r     <= 1'b0;
      pend_idx_r <= '0;
    end else begin
      pend_r     <= mem_re;
      pend_idx_r <= rd_idx_r[IDX_W-1:0];
      if (in_fire || ((state_r == S_SCAN) && pass_done)) begin
        rd_idx_r <= '0;
      end else if (mem_re) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  // Search accumulators: first match, first empty, oldest frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (in_fire) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if ((state_r == S_SCAN) && pend_r) begin
      if (!hit_r && ent_valid && (ent_page == page_r)) begin
        hit_r <= 1'b1;
      end
      if (!empty_r && !ent_valid) begin
        empty_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r      <= PW'(in_page_number);
      best_rank_r <= '0;
      best_idx_r  <= '0;
    end else if ((state_r == S_SCAN) && pend_r) begin
      if (!hit_r && ent_valid && (ent_page == page_r)) begin
        hit_idx_r  <= pend_idx_r;
        hit_rank_r <= ent_rank;
      end
      if (!empty_r && !ent_valid) begin
        empty_idx_r <= pend_idx_r;
      end
      if (ent_rank > best_rank_r) begin
        best_rank_r <= ent_rank;
        best_idx_r  <= pend_idx_r;
      end
    end
  end

  // Target frame and aging bound, fixed when the search ends
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && pass_done) begin
      f_r         <= dec_f;
      bound_all_r <= !hit_r && empty_r;
      bound_r     <= hit_r ? hit_rank_r : best_rank_r;
    end
  end

  // Frame valid flags; a fault into an empty frame fills it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if ((state_r == S_SCAN) && pass_done && !hit_r && empty_r) begin
      valid_r[dec_f] <= 1'b1;
    end
  end

  // Output register
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r          <= hit_r;
      out_frame_index_r  <= OUT_IDX_W'(f_r);
      out_filled_empty_r <= !hit_r && empty_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame_index  = out_frame_index_r;
  assign out_filled_empty = out_filled_empty_r;

  // A hit never reports a filled frame
  a_hit_not_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_filled_empty_r))
    else $error("hit and filled_empty both set");

  // The frame being updated lies within the active set
  a_target_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> (CNT_W'(f_r) < n_act))
    else $error("update target outside active frames");

  // The target frame is always occupied once the search has ended
  a_target_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> valid_r[f_r])
    else $error("update target frame not valid");

  // Write-back never collides with the read issued in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != rd_idx_r[IDX_W-1:0]))
    else $error("read and write to the same entry");

  // A result is loaded only after the write-back pass
  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_RESULT) |-> $past(state_r == S_UPDATE))
    else $error("result stage entered out of order");

endmodule
